FILE: design/tdpbs_pkg.sv
// Package: shared types, constants and helpers for the tail-drop packet buffer scheduler.
`timescale 1ns / 1ps

package tdpbs_pkg;

   // Ring geometry
   localparam int BUFFER_DEPTH = 64;
   localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int OCC_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int BSIZE_W      = 7;
   localparam int CAP_W        = (OCC_W > BSIZE_W) ? OCC_W : BSIZE_W;

   // Field widths
   localparam int TIME_W = 32;
   localparam int PROC_W = 16;

   typedef struct packed {
      logic [TIME_W-1:0] arr_time;
      logic [PROC_W-1:0] proc_time;
      logic              last_packet;
   } req_payload_type;

   typedef struct packed {
      logic              dropped;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] busy_until;
      logic              last_packet_out;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_RETIRE
   } state_type;

   // Ring position after p, wrapping at the depth
   function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] r;
      if (p == IDX_W'(BUFFER_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: design/tail_drop_packet_buffer_scheduler_top.sv
// An accepted item is registered; entries finished by its arrival retire one per cycle;
// its result is registered once the output register is free; a new item is taken only when idle.
// The input is taken while an earlier result still waits in the output register.
// Reset (synchronous, active high) empties the ring, zeroes last finish and sets capacity to 1.
// The finish ring has no reset; only entries written in the current batch are ever read.
// A packet marked last empties the ring again once its result is produced.
`timescale 1ns / 1ps

module tail_drop_packet_buffer_scheduler_top (
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tdpbs_pkg::req_payload_type req_data,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tdpbs_pkg::rsp_payload_type rsp_data,
   // capacity register
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tdpbs_pkg::BSIZE_W-1:0] csr_data
);

   import tdpbs_pkg::*;

   // Control and state registers
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [TIME_W-1:0]  last_finish_ff, last_finish_in;
   logic [BSIZE_W-1:0] buffer_size_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers
   req_payload_type    item_ff, item_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   // Finish ring
   logic [TIME_W-1:0]  ring_mem [BUFFER_DEPTH];
   logic [TIME_W-1:0]  rd_data_ff;
   logic               ring_we;
   logic [TIME_W-1:0]  ring_wdata;

   // Scratch
   logic [CAP_W-1:0]   cap;
   logic [CAP_W-1:0]   bsize_ext;
   logic               full;
   logic               out_free;
   logic [TIME_W-1:0]  start_val;
   logic [TIME_W:0]    fin_sum;
   logic [TIME_W-1:0]  fin_val;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective capacity: zero acts as one, clipped to the ring depth
   always_comb begin
      bsize_ext = CAP_W'(buffer_size_ff);
      if (bsize_ext == '0) begin
         cap = CAP_W'(1);
      end else if (bsize_ext > CAP_W'(BUFFER_DEPTH)) begin
         cap = CAP_W'(BUFFER_DEPTH);
      end else begin
         cap = bsize_ext;
      end
      full = (CAP_W'(occ_ff) >= cap);
   end

   // Start time and saturating finish time of the held item
   always_comb begin
      start_val = (item_ff.arr_time > last_finish_ff) ? item_ff.arr_time
                                                      : last_finish_ff;
      fin_sum   = {1'b0, start_val} + (TIME_W + 1)'(item_ff.proc_time);
      fin_val   = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath control
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      last_finish_in = last_finish_ff;
      item_in        = item_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      ring_we        = 1'b0;
      ring_wdata     = fin_val;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            if ((occ_ff != '0) && (rd_data_ff <= item_ff.arr_time)) begin
               // retire the head entry, one per cycle
               head_in = next_pos(head_ff);
               occ_in  = occ_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.last_packet_out = item_ff.last_packet;
               if (full) begin
                  rsp_data_in.dropped    = 1'b1;
                  rsp_data_in.start_time = '0;
                  rsp_data_in.busy_until = last_finish_ff;
               end else begin
                  rsp_data_in.dropped    = 1'b0;
                  rsp_data_in.start_time = start_val;
                  rsp_data_in.busy_until = fin_val;
                  ring_we                = 1'b1;
                  tail_in                = next_pos(tail_ff);
                  occ_in                 = occ_ff + 1'b1;
                  last_finish_in         = fin_val;
               end
               // end of batch: start empty at time zero
               if (item_ff.last_packet) begin
                  head_in        = '0;
                  tail_in        = '0;
                  occ_in         = '0;
                  last_finish_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         occ_ff         <= '0;
         last_finish_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         buffer_size_ff <= BSIZE_W'(1);
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         occ_ff         <= occ_in;
         last_finish_ff <= last_finish_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            buffer_size_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Finish ring: one write at the tail, registered read following the head
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[tail_ff] <= ring_wdata;
      end
      rd_data_ff <= ring_mem[head_in];
   end

endmodule
